// ----- src/hjse_pkg.sv -----
// Shared types and constants of the histogram join size estimator.
`timescale 1ns / 1ps
package hjse_pkg;

   localparam int BUCKET_DEPTH = 1024;
   localparam int ADDR_W       = $clog2(BUCKET_DEPTH);
   localparam int HASH_SHIFT   = 11;
   localparam int HIST_W       = 16;
   localparam int COUNT_W      = 32;
   localparam int M_W          = 11;
   localparam int ACC_W        = 2 * HIST_W + ADDR_W;
   localparam int DM_W         = ACC_W + M_W;
   localparam int EST_W        = 64;
   localparam int STEP_W       = 7;

   localparam logic [1:0] FUNC_LEFT    = 2'd0;
   localparam logic [1:0] FUNC_RIGHT   = 2'd1;
   localparam logic [1:0] FUNC_FINISH  = 2'd2;
   localparam logic [1:0] FUNC_IGNORED = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_RD,
      ST_WR,
      ST_WALK,
      ST_TAIL,
      ST_MUL,
      ST_CMP,
      ST_QDIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                start;
      logic [EST_W-1:0]    dividend;
      logic [STEP_W-1:0]   steps;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [EST_W-1:0]    quot;
      logic [M_W-1:0]      rem;
   } div_rsp_type;

endpackage

// ----- src/hjse_div.sv -----
// Restoring divider, one quotient bit per cycle, by an 11-bit divisor.
`timescale 1ns / 1ps
module hjse_div (
   input  logic                      clock,
   input  logic                      reset,
   input  hjse_pkg::div_req_type     req,
   input  logic [hjse_pkg::M_W-1:0]  divisor,
   output hjse_pkg::div_rsp_type     rsp
);

   logic [hjse_pkg::EST_W-1:0]  num_ff, num_in;
   logic [hjse_pkg::EST_W-1:0]  quot_ff, quot_in;
   logic [hjse_pkg::M_W-1:0]    rem_ff, rem_in;
   logic [hjse_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [hjse_pkg::M_W:0]      trial;
   logic                        ge;

   // The dividend arrives left aligned, so the leading bit is always next.
   assign trial = {rem_ff, num_ff[hjse_pkg::EST_W-1]};
   assign ge    = trial >= {1'b0, divisor};

   always_comb begin
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = req.dividend;
         quot_in = '0;
         rem_in  = '0;
         cnt_in  = req.steps;
         run_in  = 1'b1;
      end else if (run_ff) begin
         num_in  = {num_ff[hjse_pkg::EST_W-2:0], 1'b0};
         quot_in = {quot_ff[hjse_pkg::EST_W-2:0], ge};
         rem_in  = ge ? hjse_pkg::M_W'(trial - {1'b0, divisor})
                      : trial[hjse_pkg::M_W-1:0];
         cnt_in  = cnt_ff - hjse_pkg::STEP_W'(1);
         if (cnt_ff == hjse_pkg::STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

// ----- src/histogram_join_size_estimator.sv -----
// Top level of the histogram join size estimator.
// Usage: the req channel carries one beat per item (req_func, req_hash).
// An insert beat (left or right side) picks bucket (hash >> 11) mod m with
// a serial divider, then reads and rewrites that bucket of the side's
// histogram memory; the next beat can be accepted only after the 21
// divider steps and the memory read and write. A finish beat walks all
// 1024 buckets of both memories, one bucket per cycle through the two
// read ports at the shared sequencing address, summing products and
// writing zero behind it, then forms n_left*n_right and, if needed,
// divides it by m over 64 divider steps.
// The rsp channel carries one beat with rsp_estimate per finish. The
// result sits in an output register, so the block goes on accepting
// inserts while the receiver holds rsp_stall; only a second finish result
// waits until the first beat has been taken.
// The csr channel writes the bucket count (always ready); write it only
// while the block is idle. After reset the block clears both memories,
// one bucket per cycle, holding req_stall high until all are cleared.
`timescale 1ns / 1ps
module histogram_join_size_estimator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_hash,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_estimate,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data
);

   localparam int AW = hjse_pkg::ADDR_W;
   localparam int HW = hjse_pkg::HIST_W;
   localparam int CW = hjse_pkg::COUNT_W;
   localparam int MW = hjse_pkg::M_W;
   localparam int EW = hjse_pkg::EST_W;

   hjse_pkg::state_type state_ff, state_in;

   logic [AW-1:0]   addr_ff, addr_in;
   logic            side_ff;
   logic [MW-1:0]   bucket_count_ff;
   logic [MW-1:0]   m;
   logic [CW-1:0]   left_count_ff, right_count_ff;
   logic [HW-1:0]   left_mem  [hjse_pkg::BUCKET_DEPTH];
   logic [HW-1:0]   right_mem [hjse_pkg::BUCKET_DEPTH];
   logic [HW-1:0]   ldata_ff, rdata_ff;
   logic            lwe, rwe;
   logic [HW-1:0]   wdata;
   logic            vld1_ff, vld2_ff;
   logic [2*HW-1:0] prod_ff;
   logic [hjse_pkg::ACC_W-1:0] acc_ff;
   logic [hjse_pkg::DM_W-1:0]  dm_ff;
   logic [EW-1:0]   p_ff;
   logic [EW-1:0]   est_ff, est_in;
   logic            rsp_valid_ff;
   logic            req_accept, rsp_load;
   logic            last_addr;

   hjse_pkg::div_req_type div_req;
   hjse_pkg::div_rsp_type div_rsp;

   // Out-of-range bucket counts act as the nearest legal value.
   assign m = (bucket_count_ff == '0) ? MW'(1) :
              (bucket_count_ff > MW'(hjse_pkg::BUCKET_DEPTH)) ?
              MW'(hjse_pkg::BUCKET_DEPTH) : bucket_count_ff;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != hjse_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign last_addr  = (addr_ff == AW'(hjse_pkg::BUCKET_DEPTH - 1));

   hjse_div u_div (
      .clock   (clock),
      .reset   (reset),
      .req     (div_req),
      .divisor (m),
      .rsp     (div_rsp)
   );

   // Next state and sequencing address.
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      case (state_ff)
         hjse_pkg::ST_CLEAR: begin
            addr_in = addr_ff + AW'(1);
            if (last_addr) state_in = hjse_pkg::ST_IDLE;
         end
         hjse_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_func == hjse_pkg::FUNC_LEFT || req_func == hjse_pkg::FUNC_RIGHT)
                  state_in = hjse_pkg::ST_DIV;
               else if (req_func == hjse_pkg::FUNC_FINISH) begin
                  state_in = hjse_pkg::ST_WALK;
                  addr_in  = '0;
               end
            end
         end
         hjse_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               state_in = hjse_pkg::ST_RD;
               addr_in  = div_rsp.rem[AW-1:0];
            end
         end
         hjse_pkg::ST_RD:   state_in = hjse_pkg::ST_WR;
         hjse_pkg::ST_WR:   state_in = hjse_pkg::ST_IDLE;
         hjse_pkg::ST_WALK: begin
            addr_in = addr_ff + AW'(1);
            if (last_addr) state_in = hjse_pkg::ST_TAIL;
         end
         hjse_pkg::ST_TAIL: begin
            if (!vld1_ff && !vld2_ff) state_in = hjse_pkg::ST_MUL;
         end
         hjse_pkg::ST_MUL:  state_in = hjse_pkg::ST_CMP;
         hjse_pkg::ST_CMP: begin
            if (EW'(dm_ff) > p_ff) state_in = hjse_pkg::ST_QDIV;
            else                   state_in = hjse_pkg::ST_OUT;
         end
         hjse_pkg::ST_QDIV: begin
            if (div_rsp.done) state_in = hjse_pkg::ST_OUT;
         end
         hjse_pkg::ST_OUT: begin
            if (rsp_load) state_in = hjse_pkg::ST_IDLE;
         end
         default: state_in = hjse_pkg::ST_IDLE;
      endcase
   end

   // Memory writes, divider launches and result loading.
   always_comb begin
      lwe     = 1'b0;
      rwe     = 1'b0;
      wdata   = '0;
      div_req = '0;
      est_in  = est_ff;
      rsp_load = 1'b0;
      case (state_ff)
         hjse_pkg::ST_CLEAR, hjse_pkg::ST_WALK: begin
            lwe = 1'b1;
            rwe = 1'b1;
         end
         hjse_pkg::ST_IDLE: begin
            // The 21 significant hash bits are left aligned for the divider.
            div_req.start    = req_accept &&
                               (req_func == hjse_pkg::FUNC_LEFT ||
                                req_func == hjse_pkg::FUNC_RIGHT);
            div_req.dividend = {req_hash[31:hjse_pkg::HASH_SHIFT],
                                hjse_pkg::HASH_SHIFT'(0),
                                (EW - 32)'(0)};
            div_req.steps    = hjse_pkg::STEP_W'(32 - hjse_pkg::HASH_SHIFT);
         end
         hjse_pkg::ST_WR: begin
            lwe   = !side_ff;
            rwe   = side_ff;
            wdata = (side_ff ? rdata_ff : ldata_ff) + HW'(1);
         end
         hjse_pkg::ST_CMP: begin
            div_req.start    = (EW'(dm_ff) > p_ff);
            div_req.dividend = p_ff;
            div_req.steps    = hjse_pkg::STEP_W'(EW);
            est_in           = '0;
         end
         hjse_pkg::ST_QDIV: begin
            if (div_rsp.done)
               est_in = EW'(acc_ff) - (div_rsp.quot + EW'(div_rsp.rem != '0));
         end
         hjse_pkg::ST_OUT: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
         end
      endcase
   end

   // Histogram memories: the read port follows the sequencing address.
   always_ff @(posedge clock) begin
      if (lwe) left_mem[addr_ff] <= wdata;
      if (rwe) right_mem[addr_ff] <= wdata;
      ldata_ff <= left_mem[addr_ff];
      rdata_ff <= right_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= hjse_pkg::ST_CLEAR;
         addr_ff         <= '0;
         bucket_count_ff <= MW'(hjse_pkg::BUCKET_DEPTH);
         left_count_ff   <= '0;
         right_count_ff  <= '0;
         vld1_ff         <= 1'b0;
         vld2_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         if (csr_valid && csr_ready) bucket_count_ff <= csr_data;
         if (req_accept && req_func == hjse_pkg::FUNC_LEFT && left_count_ff != '1)
            left_count_ff <= left_count_ff + CW'(1);
         if (req_accept && req_func == hjse_pkg::FUNC_RIGHT && right_count_ff != '1)
            right_count_ff <= right_count_ff + CW'(1);
         if (state_ff == hjse_pkg::ST_MUL) begin
            left_count_ff  <= '0;
            right_count_ff <= '0;
         end
         vld1_ff <= (state_ff == hjse_pkg::ST_WALK);
         vld2_ff <= vld1_ff;
         if (rsp_load)                     rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
      if (req_accept) side_ff <= req_func[0];
      // Dot product pipeline: registered product, then accumulate.
      prod_ff <= ldata_ff * rdata_ff;
      if (req_accept && req_func == hjse_pkg::FUNC_FINISH) acc_ff <= '0;
      else if (vld2_ff) acc_ff <= acc_ff + hjse_pkg::ACC_W'(prod_ff);
      if (state_ff == hjse_pkg::ST_MUL) begin
         dm_ff <= acc_ff * m;
         p_ff  <= left_count_ff * right_count_ff;
      end
      est_ff <= est_in;
      if (rsp_load) rsp_estimate <= est_ff;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- tb/hjse_checker.sv -----
// Checker that predicts the join size estimate of every finish and compares it with rsp beats.
`timescale 1ns / 1ps
module hjse_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_hash,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_estimate,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [10:0] csr_data,
   output int          fail_count,
   output int          pending_estimates
);

   logic [hjse_pkg::HIST_W-1:0]  left_hist  [hjse_pkg::BUCKET_DEPTH];
   logic [hjse_pkg::HIST_W-1:0]  right_hist [hjse_pkg::BUCKET_DEPTH];
   logic [hjse_pkg::COUNT_W-1:0] left_n, right_n;
   logic [hjse_pkg::M_W-1:0]     bucket_reg;
   logic [63:0]                  estimate_q[$];

   function automatic logic [63:0] join_estimate(logic [10:0] m);
      logic [63:0] dot, p, q;
      dot = 0;
      for (int i = 0; i < hjse_pkg::BUCKET_DEPTH; i++)
         dot += 64'(left_hist[i]) * 64'(right_hist[i]);
      p = 64'(left_n) * 64'(right_n);
      // The product dot*m stays below 2^53, so it fits in 64 bits; compare wide.
      if (72'(dot) * 72'(m) <= 72'(p)) return 64'd0;
      q = p / m + ((p % m) != 0 ? 64'd1 : 64'd0);
      return dot - q;
   endfunction

   always @(posedge clock) begin
      logic [10:0] m;
      logic [hjse_pkg::ADDR_W-1:0] idx;
      logic [63:0] got;
      if (reset) begin
         for (int i = 0; i < hjse_pkg::BUCKET_DEPTH; i++) begin
            left_hist[i]  = '0;
            right_hist[i] = '0;
         end
         left_n     = '0;
         right_n    = '0;
         bucket_reg = 11'd1024;
         estimate_q.delete();
         fail_count = 0;
      end else begin
         // The rsp beat is checked before this edge's req beat is folded in.
         if (rsp_valid && !rsp_stall) begin
            if (estimate_q.size() == 0) begin
               $display("%0t: unexpected estimate beat %0d", $time, rsp_estimate);
               fail_count++;
            end else begin
               got = estimate_q.pop_front();
               if (got !== rsp_estimate) begin
                  $display("%0t: estimate mismatch expected %0d actual %0d",
                           $time, got, rsp_estimate);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            m = bucket_reg;
            if (m < 1) m = 1;
            if (m > hjse_pkg::BUCKET_DEPTH) m = 11'(hjse_pkg::BUCKET_DEPTH);
            if (req_func == hjse_pkg::FUNC_LEFT || req_func == hjse_pkg::FUNC_RIGHT) begin
               idx = hjse_pkg::ADDR_W'((req_hash >> hjse_pkg::HASH_SHIFT) % m);
               if (req_func == hjse_pkg::FUNC_LEFT) begin
                  left_hist[idx] = left_hist[idx] + 1'b1;
                  if (left_n != '1) left_n = left_n + 1;
               end else begin
                  right_hist[idx] = right_hist[idx] + 1'b1;
                  if (right_n != '1) right_n = right_n + 1;
               end
            end else if (req_func == hjse_pkg::FUNC_FINISH) begin
               estimate_q = {estimate_q, join_estimate(m)};
               for (int i = 0; i < hjse_pkg::BUCKET_DEPTH; i++) begin
                  left_hist[i]  = '0;
                  right_hist[i] = '0;
               end
               left_n  = '0;
               right_n = '0;
            end
         end
         if (csr_valid && csr_ready) bucket_reg = csr_data;
      end
      pending_estimates = estimate_q.size();
   end

endmodule

// ----- tb/tb_histogram_join_size_estimator.sv -----
// Stimulus and verdict for the histogram join size estimator.
`timescale 1ns / 1ps
module tb_histogram_join_size_estimator;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [1:0]  req_func;
   logic [31:0] req_hash;
   logic        rsp_valid, rsp_stall;
   logic [63:0] rsp_estimate;
   logic        csr_valid, csr_ready;
   logic [10:0] csr_data;
   int          fail_count, pending_estimates;

   // Idle odds in percent for the sender and the receiver.
   int          send_idle_pct, recv_idle_pct;
   // While set, the receiver holds rsp_stall high regardless of the odds.
   bit          long_hold;
   int          quiet_cycles;

   localparam int WATCHDOG = 20000;

   histogram_join_size_estimator dut (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_hash,
      .rsp_valid, .rsp_stall, .rsp_estimate, .csr_valid, .csr_ready, .csr_data
   );

   hjse_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_hash,
      .rsp_valid, .rsp_stall, .rsp_estimate, .csr_valid, .csr_ready, .csr_data,
      .fail_count, .pending_estimates
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // The receiver draws a fresh stall decision at every falling edge.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
   end

   // The watchdog counts cycles in which no beat of either channel is taken.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Offers one req beat after a random gap and holds it until it is taken.
   // The beat stays on the bus until the next call or release_req replaces it.
   task automatic send_beat(input logic [1:0] func, input logic [31:0] hash);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_hash  <= hash;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Takes the last taken beat off the req channel.
   task automatic release_req();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Writes bucket_count once every estimate is in and the finish walk has ended.
   task automatic write_buckets(input logic [10:0] value);
      release_req();
      while (pending_estimates != 0) @(negedge clock);
      repeat (1200) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A random hash whose bucket field lands mostly in a few buckets so that
   // the two sides actually collide.
   function automatic logic [31:0] clustered_hash();
      logic [31:0] h;
      h = $urandom();
      if ($urandom_range(3) != 0) h[31:11] = 21'($urandom_range(15));
      return h;
   endfunction

   task automatic random_phase(input int items);
      int k;
      int r;
      for (k = 0; k < items; k++) begin
         r = int'($urandom_range(99));
         if (r < 47)      send_beat(hjse_pkg::FUNC_LEFT, clustered_hash());
         else if (r < 94) send_beat(hjse_pkg::FUNC_RIGHT, clustered_hash());
         else if (r < 97) send_beat(hjse_pkg::FUNC_FINISH, $urandom());
         else             send_beat(hjse_pkg::FUNC_IGNORED, $urandom());
      end
      send_beat(hjse_pkg::FUNC_FINISH, $urandom());
   endtask

   initial begin
      logic [10:0] settings[6];
      settings = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd37, 11'd1025};
      send_idle_pct = 15;
      recv_idle_pct = 83;
      long_hold = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_func  = hjse_pkg::FUNC_LEFT;
      req_hash  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed part: finish with no inserts, extreme hashes, both sides,
      // the unused selector, and a finish that sees colliding buckets.
      send_beat(hjse_pkg::FUNC_FINISH, '0);
      send_beat(hjse_pkg::FUNC_LEFT, 32'h0000_0000);
      send_beat(hjse_pkg::FUNC_LEFT, 32'hFFFF_FFFF);
      send_beat(hjse_pkg::FUNC_RIGHT, 32'hFFFF_FFFF);
      send_beat(hjse_pkg::FUNC_RIGHT, 32'h0000_0000);
      send_beat(hjse_pkg::FUNC_RIGHT, 32'h0000_07FF);
      send_beat(hjse_pkg::FUNC_IGNORED, 32'hFFFF_FFFF);
      send_beat(hjse_pkg::FUNC_LEFT, 32'h5555_5555);
      send_beat(hjse_pkg::FUNC_RIGHT, 32'hAAAA_AAAA);
      send_beat(hjse_pkg::FUNC_FINISH, 32'hFFFF_FFFF);
      // A larger m fills high buckets; a later small m must still count them.
      send_beat(hjse_pkg::FUNC_LEFT, 32'h001F_F800);
      send_beat(hjse_pkg::FUNC_RIGHT, 32'h001F_F800);
      write_buckets(11'd3);
      send_beat(hjse_pkg::FUNC_LEFT, 32'h1234_5678);
      send_beat(hjse_pkg::FUNC_FINISH, '0);

      // Receiver holds off for a long stretch while inserts and two finishes
      // pile up behind the output register.
      long_hold = 1;
      fork
         begin
            repeat (3000) @(negedge clock);
            long_hold = 0;
         end
         begin
            send_beat(hjse_pkg::FUNC_FINISH, '0);
            repeat (10) send_beat(hjse_pkg::FUNC_LEFT, 32'h0);
            send_beat(hjse_pkg::FUNC_FINISH, '0);
            send_beat(hjse_pkg::FUNC_RIGHT, 32'h0);
            release_req();
         end
      join
      send_beat(hjse_pkg::FUNC_FINISH, '0);

      // Random part over several bucket settings and the three idle patterns.
      for (int s = 0; s < 6; s++) begin
         if (s == 2) begin
            send_idle_pct = 83;
            recv_idle_pct = 15;
         end else if (s == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_buckets(settings[s]);
         random_phase(310);
      end
      release_req();

      while (pending_estimates != 0) @(negedge clock);
      repeat (1200) @(negedge clock);
      if (fail_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
